/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-implication check, sampled on the rising clock, off during reset
`define CHK_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication check, sampled on the rising clock, off during reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("check failed");

`endif

/* sv/sudq_pkg.sv */
`timescale 1ns / 1ps

package sudq_pkg;

	// Defaults for the top-level parameters
	localparam int CAPACITY_DEF = 16;
	localparam int KEY_BITS_DEF = 32;

	// Fixed port widths
	localparam int OP_W     = 3;
	localparam int KEY_IN_W = 32;
	localparam int STAT_W   = 2;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_POP_MIN = 3'd1,
		OP_POP_MAX = 3'd2,
		OP_FIND    = 3'd3,
		OP_REMOVE  = 3'd4
	} op_t;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	// Shift command broadcast to every cell
	typedef struct packed {
		logic ins;      // open a slot at the insert point, shift the rest up
		logic del_all;  // shift the whole row down by one
		logic del_ge;   // shift down every cell not below the key
	} cell_ctrl_t;

endpackage

/* sv/sorted_unique_deque_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sorted set of up to CAPACITY distinct keys held in a row of cells, smallest
// in cell 0. Each beat is one operation (insert, pop smallest, pop largest,
// find, remove): the key is broadcast to all cells, each cell compares it
// with its own entry in parallel, and the row shifts up or down by one cell
// where needed as the beat is taken. One result beat follows each input beat
// from an output register on the next cycle; a new input beat is taken
// every cycle as long as the previous result is taken or is being taken, so
// the sustained rate is one beat per cycle. No clearing pass after reset.
module sorted_unique_deque_queue
	import sudq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [KEY_IN_W-1:0] key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [KEY_IN_W-1:0] result_key,
	output logic [CNT_W-1:0]    count
);

	localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [KW-1:0]       k;
	logic                acc;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	cell_ctrl_t          ctrl;
	cell_ctrl_t          ctrl_req;
	logic [KW-1:0]       key_vec [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic                hit;
	logic                full;
	logic [KW-1:0]       min_key;
	logic [KW-1:0]       max_key;
	logic [STAT_W-1:0]   st_nxt;
	logic [KW-1:0]       rk_nxt;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [KEY_IN_W-1:0] result_key_q;
	logic [CNT_W-1:0]    count_out_q;

	assign k        = key[KW-1:0];
	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	// Row of key cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0] lkey;
		logic          llt;
		logic [KW-1:0] rkey;

		if (i == 0) begin : g_first
			assign lkey = key_vec[i];
			assign llt  = 1'b1;
		end else begin : g_mid
			assign lkey = key_vec[i-1];
			assign llt  = lt_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rkey = key_vec[i];
		end else begin : g_inner
			assign rkey = key_vec[i+1];
		end

		sudq_cell #(
			.KW   (KW),
			.CNT_W(CNT_W),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.k        (k),
			.held     (count_q),
			.left_key (lkey),
			.left_lt  (llt),
			.right_key(rkey),
			.key_q    (key_vec[i]),
			.lt       (lt_vec[i]),
			.eq       (eq_vec[i])
		);
	end

	// Gather hit flag and the largest held key
	always_comb begin
		max_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CNT_W'(i + 1)) begin
				max_key = max_key | key_vec[i];
			end
		end
	end

	assign hit     = |eq_vec;
	assign full    = count_q == CAP_C;
	assign min_key = key_vec[0];

	// Decode the operation into a shift command, status and new count
	always_comb begin
		ctrl_req  = '0;
		count_nxt = count_q;
		st_nxt    = ST_OK;
		rk_nxt    = '0;
		unique case (operation)
			OP_INSERT: begin
				if (hit) begin
					st_nxt = ST_DUP;
				end else if (full) begin
					st_nxt = ST_FULL;
				end else begin
					ctrl_req.ins = 1'b1;
					count_nxt    = count_q + ONE_C;
				end
			end
			OP_POP_MIN: begin
				if (count_q == '0) begin
					st_nxt = ST_MISS;
				end else begin
					ctrl_req.del_all = 1'b1;
					count_nxt        = count_q - ONE_C;
					rk_nxt           = min_key;
				end
			end
			OP_POP_MAX: begin
				if (count_q == '0) begin
					st_nxt = ST_MISS;
				end else begin
					count_nxt = count_q - ONE_C;
					rk_nxt    = max_key;
				end
			end
			OP_FIND: begin
				if (hit) begin
					rk_nxt = k;
				end else begin
					st_nxt = ST_MISS;
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					ctrl_req.del_ge = 1'b1;
					count_nxt       = count_q - ONE_C;
					rk_nxt          = k;
				end else begin
					st_nxt = ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	// Move the row only on an accepted beat
	assign ctrl = acc ? ctrl_req : '0;

	// Hold the count of stored keys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q     <= st_nxt;
			result_key_q <= KEY_IN_W'(rk_nxt);
			count_out_q  <= count_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign result_key = result_key_q;
	assign count      = count_out_q;

	`CHK_NOW(a_count_cap, clk, arst_n, 1'b1, count_q <= CAP_C)
	`CHK_NEXT(a_ins_grows, clk, arst_n,
		acc && (operation == OP_INSERT) && !hit && !full,
		count_q == $past(count_q) + ONE_C)
	`CHK_NEXT(a_pop_empty, clk, arst_n,
		acc && ((operation == OP_POP_MIN) || (operation == OP_POP_MAX)) && (count_q == '0),
		out_valid_q && (status_q == ST_MISS) && (count_q == '0))

endmodule

/* sv/sudq_cell.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sudq_cell
	import sudq_pkg::*;
#(
	parameter int KW    = 32,
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [KW-1:0]    k,
	input  logic [CNT_W-1:0] held,
	input  logic [KW-1:0]    left_key,
	input  logic             left_lt,
	input  logic [KW-1:0]    right_key,
	output logic [KW-1:0]    key_q,
	output logic             lt,
	output logic             eq
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic occ;

	// Compare the broadcast key against the held key
	assign occ = IDX_C < held;
	assign lt  = occ && (key_q < k);
	assign eq  = occ && (key_q == k);

	// Shift up on insert, down on delete, else hold
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!lt) begin
				key_q <= left_lt ? k : left_key;
			end
		end else if (ctrl.del_all || (ctrl.del_ge && !lt)) begin
			key_q <= right_key;
		end
	end

	`CHK_NOW(a_sorted, clk, arst_n, (IDX != 0) && occ, left_key < key_q)

endmodule

/* sim/sorted_unique_deque_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_unique_deque_queue_tb;
	import sudq_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int KEY_BITS     = KEY_BITS_DEF;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int RANDOM_BEATS = 1350;

	// Operation codes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [KEY_IN_W-1:0] rkey;
		logic [CNT_W-1:0]    cnt;
	} outcome_t;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [KEY_IN_W-1:0] k;
		int                  reps;
		logic [KEY_IN_W-1:0] step;
		bit                  typed;
		outcome_t            want;
	} plan_row_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_THIRD, RX_LONG_STALL} rx_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     operation = '0;
	logic [KEY_IN_W-1:0] key = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [KEY_IN_W-1:0] result_key;
	logic [CNT_W-1:0]    count;

	// Shadow copy of the sorted set and the outcomes still owed by the block
	logic [KEY_IN_W-1:0] shadow_keys[$];
	outcome_t            pending_outcomes[$];

	int errors = 0;
	int beats_sent = 0;
	int random_beats = 0;
	int results_checked = 0;
	int n_full = 0;
	int n_dup = 0;
	int n_miss = 0;
	int burst_left = 0;
	int unsigned cyc = 0;
	rx_pattern_t rx_pattern = RX_OPEN;

	sorted_unique_deque_queue #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.result_key(result_key),
		.count     (count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("sorted_unique_deque_queue verification failed");
		$finish;
	end

	// Apply one operation to the shadow set and return what the block must answer
	function automatic outcome_t apply_to_shadow_set(input logic [OP_W-1:0] op,
			input logic [KEY_IN_W-1:0] k);
		outcome_t o;
		int pos;
		bit hit;
		o = '0;
		pos = 0;
		while (pos < shadow_keys.size() && shadow_keys[pos] < k)
			pos++;
		hit = (pos < shadow_keys.size()) && (shadow_keys[pos] == k);
		case (op)
			OP_INSERT: begin
				if (hit)
					o.status = ST_DUP;
				else if (shadow_keys.size() >= CAPACITY)
					o.status = ST_FULL;
				else
					shadow_keys.insert(pos, k);
			end
			OP_POP_MIN: begin
				if (shadow_keys.size() == 0)
					o.status = ST_MISS;
				else
					o.rkey = shadow_keys.pop_front();
			end
			OP_POP_MAX: begin
				if (shadow_keys.size() == 0)
					o.status = ST_MISS;
				else
					o.rkey = shadow_keys.pop_back();
			end
			OP_FIND, OP_REMOVE: begin
				if (!hit) begin
					o.status = ST_MISS;
				end else begin
					o.rkey = k;
					if (op == OP_REMOVE)
						shadow_keys.delete(pos);
				end
			end
			default: ;
		endcase
		o.cnt = CNT_W'(shadow_keys.size());
		return o;
	endfunction

	// Draw a key: often one already held, else near zero, near the top or anywhere
	function automatic logic [KEY_IN_W-1:0] pick_key(input int held_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < held_pct && shadow_keys.size() != 0)
			return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
		r = $urandom_range(0, 2);
		if (r == 0)
			return KEY_IN_W'($urandom_range(0, 47));
		if (r == 1)
			return 32'hFFFF_FFFF - KEY_IN_W'($urandom_range(0, 47));
		return $urandom;
	endfunction

	function automatic void check_field(input string name, input logic [KEY_IN_W-1:0] want,
			input logic [KEY_IN_W-1:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
			errors++;
		end
	endfunction

	// Send one beat in bursts; once taken, queue the outcome it must produce
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_IN_W-1:0] k,
			input bit typed, input outcome_t want);
		outcome_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_to_shadow_set(op, k);
		if (typed)
			predicted = want;
		if (predicted.status == ST_FULL)
			n_full++;
		if (predicted.status == ST_DUP)
			n_dup++;
		if (predicted.status == ST_MISS)
			n_miss++;
		pending_outcomes.push_back(predicted);
		beats_sent++;
	endtask

	// Stall the result side on a pattern that changes every so often
	always @(posedge clk) begin
		cyc++;
		if (cyc % 97 == 0)
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
		case (rx_pattern)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
			RX_THIRD:  out_ready <= (cyc % 3 == 0);
			default:   out_ready <= (cyc % 16 >= 11);
		endcase
	end

	// Compare each result beat with the oldest pending outcome
	always @(posedge clk) begin
		outcome_t oldest;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none, got %0h %0h %0h",
					$time, status, result_key, count);
				errors++;
			end else begin
				oldest = pending_outcomes.pop_front();
				check_field("status", KEY_IN_W'(oldest.status), KEY_IN_W'(status));
				check_field("result_key", oldest.rkey, result_key);
				check_field("count", KEY_IN_W'(oldest.cnt), KEY_IN_W'(count));
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		plan_row_t row;
		phase_t phase;
		logic [OP_W-1:0] op;
		logic [KEY_IN_W-1:0] k;
		int r;
		int seg_len;

		// Empty-store cases, removing the only key, unused codes, fill to full, then ops on the full store
		plan.push_back('{OP_POP_MIN, 32'h0, 1, 32'h0, 1'b1, '{ST_MISS, 32'h0, 5'd0}});
		plan.push_back('{OP_POP_MAX, 32'hFFFF_FFFF, 1, 32'h0, 1'b1, '{ST_MISS, 32'h0, 5'd0}});
		plan.push_back('{OP_FIND, 32'h0, 1, 32'h0, 1'b1, '{ST_MISS, 32'h0, 5'd0}});
		plan.push_back('{OP_INSERT, 32'h5, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd1}});
		plan.push_back('{OP_REMOVE, 32'h5, 1, 32'h0, 1'b1, '{ST_OK, 32'h5, 5'd0}});
		plan.push_back('{OP_POP_MAX, 32'h0, 1, 32'h0, 1'b1, '{ST_MISS, 32'h0, 5'd0}});
		plan.push_back('{OP_SPARE_LO, 32'hAAAA_5555, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd0}});
		plan.push_back('{OP_SPARE_HI, 32'h5555_AAAA, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd0}});
		plan.push_back('{OP_INSERT, 32'h0, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd1}});
		plan.push_back('{OP_INSERT, 32'hFFFF_FFFF, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd2}});
		plan.push_back('{OP_INSERT, 32'h8000_0000, 14, 32'h0101_0101, 1'b0, '0});
		plan.push_back('{OP_INSERT, 32'h1234_5678, 1, 32'h0, 1'b1, '{ST_FULL, 32'h0, 5'd16}});
		plan.push_back('{OP_INSERT, 32'h0, 1, 32'h0, 1'b1, '{ST_DUP, 32'h0, 5'd16}});
		plan.push_back('{OP_INSERT, 32'hFFFF_FFFF, 1, 32'h0, 1'b1, '{ST_DUP, 32'h0, 5'd16}});
		plan.push_back('{OP_FIND, 32'hFFFF_FFFF, 1, 32'h0, 1'b1,
			'{ST_OK, 32'hFFFF_FFFF, 5'd16}});
		plan.push_back('{OP_REMOVE, 32'h0, 1, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd15}});
		plan.push_back('{OP_REMOVE, 32'h7FFF_FFFF, 1, 32'h0, 1'b1, '{ST_MISS, 32'h0, 5'd15}});
		plan.push_back('{OP_POP_MIN, 32'h0, 1, 32'h0, 1'b0, '0});
		plan.push_back('{OP_POP_MAX, 32'h0, 1, 32'h0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 5'd13}});

		// Hold reset, then release it on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			row = plan[i];
			for (int j = 0; j < row.reps; j++)
				send_beat(row.op, row.k + row.step * KEY_IN_W'(j), row.typed, row.want);
		end

		// Random phases that push the store toward full, toward empty, or stir it
		while (random_beats < RANDOM_BEATS) begin
			phase = phase_t'($urandom_range(0, 2));
			seg_len = $urandom_range(10, 60);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					op = OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
					k = $urandom;
				end else begin
					r = $urandom_range(0, 99);
					case (phase)
						PH_FILL: begin
							op = (r < 70) ? OP_INSERT : (r < 80) ? OP_FIND :
								(r < 88) ? OP_REMOVE : (r < 94) ? OP_POP_MIN : OP_POP_MAX;
						end
						PH_DRAIN: begin
							op = (r < 15) ? OP_INSERT : (r < 25) ? OP_FIND :
								(r < 50) ? OP_REMOVE : (r < 75) ? OP_POP_MIN : OP_POP_MAX;
						end
						default: begin
							op = (r < 35) ? OP_INSERT : (r < 50) ? OP_FIND :
								(r < 70) ? OP_REMOVE : (r < 85) ? OP_POP_MIN : OP_POP_MAX;
						end
					endcase
					if (op == OP_INSERT)
						k = pick_key(15);
					else if (op == OP_FIND || op == OP_REMOVE)
						k = pick_key(60);
					else
						k = $urandom;
					random_beats++;
				end
				send_beat(op, k, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// Drain, then let the result path settle
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d operation beats (%0d random), checked %0d result beats.",
			beats_sent, random_beats, results_checked);
		$display("Outcomes seen: %0d full drops, %0d duplicates, %0d empty or missing.",
			n_full, n_dup, n_miss);
		if (errors == 0)
			$display("sorted_unique_deque_queue verification clean");
		else
			$display("sorted_unique_deque_queue verification failed");
		$finish;
	end

endmodule

/* sorted_unique_deque_queue.f */
+incdir+sv
sv/sudq_pkg.sv
sv/sudq_cell.sv
sv/sorted_unique_deque_queue.sv
sim/sorted_unique_deque_queue_tb.sv
